@@ rtl/core/lsbx_pkg.sv @@
// Shared types and constants for the LSB text extractor.
// No dependencies; used by every module in rtl/core.
package lsbx_pkg;

	// Result kinds on the output channel
	localparam logic [1:0] KIND_TEXT   = 2'd0;
	localparam logic [1:0] KIND_END    = 2'd1;
	localparam logic [1:0] KIND_NOMARK = 2'd2;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

	// Everything one pixel produces: an optional message byte (still
	// encrypted) followed by an optional end-of-run status result.
	typedef struct packed {
		logic       has_msg;
		logic [7:0] msg;
		logic       has_tail;
		logic [1:0] tail_kind;
	} pix_res_t;

endpackage

@@ rtl/core/lsbx_front.sv @@
// Front end: collects pixel LSBs into bytes, holds the last four bytes and
// spots the end marker. Depends on lsbx_pkg.
module lsbx_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic              last_pixel,
	output logic              push,
	output lsbx_pkg::pix_res_t push_data
);

	localparam logic [7:0] CH_LT = 8'h3C; // '<'
	localparam logic [7:0] CH_E  = 8'h45;
	localparam logic [7:0] CH_N  = 8'h4E;
	localparam logic [7:0] CH_D  = 8'h44;
	localparam logic [7:0] CH_GT = 8'h3E; // '>'

	logic [6:0] acc_q;
	logic [2:0] cnt_q;
	logic [7:0] held_q [4];
	logic [2:0] fill_q;
	logic       marker_q;

	logic [2:0] bits;
	logic [9:0] combined;
	logic       have;
	logic [7:0] fresh;
	logic [6:0] acc_nx;
	logic [2:0] cnt_nx;
	logic [1:0] drop;
	logic       full_hold;
	logic       match;

	always_comb begin
		bits     = {red[0], green[0], blue[0]};
		combined = {acc_q, bits};
		have     = (cnt_q >= 3'd5);
		drop     = 2'(cnt_q - 3'd5);
		fresh    = 8'(combined >> drop);
		if (have) begin
			cnt_nx = cnt_q - 3'd5;
			case (drop)
				2'd0:    acc_nx = 7'd0;
				2'd1:    acc_nx = {6'd0, bits[0]};
				2'd2:    acc_nx = {5'd0, bits[1:0]};
				default: acc_nx = 7'd0;
			endcase
		end else begin
			cnt_nx = cnt_q + 3'd3;
			acc_nx = combined[6:0];
		end
		full_hold = (fill_q >= 3'd4);
		match = have && full_hold && held_q[0] == CH_LT && held_q[1] == CH_E &&
			held_q[2] == CH_N && held_q[3] == CH_D && fresh == CH_GT;

		push_data.has_msg   = have && full_hold && !match;
		push_data.msg       = held_q[0];
		push_data.has_tail  = match || last_pixel;
		push_data.tail_kind = match ? lsbx_pkg::KIND_END : lsbx_pkg::KIND_NOMARK;
		push = take && !marker_q && (push_data.has_msg || push_data.has_tail);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			cnt_q    <= '0;
			fill_q   <= '0;
			marker_q <= 1'b0;
		end else if (take) begin
			if (last_pixel) begin
				acc_q    <= '0;
				cnt_q    <= '0;
				fill_q   <= '0;
				marker_q <= 1'b0;
			end else if (!marker_q) begin
				acc_q <= acc_nx;
				cnt_q <= cnt_nx;
				if (match) begin
					marker_q <= 1'b1;
				end else if (have && !full_hold) begin
					fill_q <= fill_q + 3'd1;
				end
			end
		end
	end

	// held bytes: payload only, read below fill count
	always_ff @(posedge clk) begin
		if (take && !marker_q && have && !match) begin
			if (full_hold) begin
				held_q[0] <= held_q[1];
				held_q[1] <= held_q[2];
				held_q[2] <= held_q[3];
				held_q[3] <= fresh;
			end else begin
				held_q[fill_q[1:0]] <= fresh;
			end
		end
	end

endmodule

@@ rtl/core/lsbx_queue.sv @@
// Small FIFO of per-pixel results between front and back end.
// Depends on lsbx_pkg.
module lsbx_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lsbx_pkg::pix_res_t push_data,
	input  logic               pop,
	output lsbx_pkg::pix_res_t head,
	output logic               nonempty,
	output logic               full
);

	lsbx_pkg::pix_res_t mem_q [lsbx_pkg::Q_DEPTH];
	logic [lsbx_pkg::Q_AW-1:0] wr_q;
	logic [lsbx_pkg::Q_AW-1:0] rd_q;
	logic [lsbx_pkg::Q_AW:0]   cnt_q;

	assign nonempty = (cnt_q != '0);
	assign full     = (cnt_q == (lsbx_pkg::Q_AW+1)'(lsbx_pkg::Q_DEPTH));
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + (lsbx_pkg::Q_AW)'(1);
			end
			if (pop) begin
				rd_q <= rd_q + (lsbx_pkg::Q_AW)'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (lsbx_pkg::Q_AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (lsbx_pkg::Q_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/lsbx_back.sv @@
// Back end: unpacks queued pixel results, decrypts message bytes and drives
// the registered output channel. Depends on lsbx_pkg.
module lsbx_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [5:0]  key,
	input  lsbx_pkg::pix_res_t head,
	input  logic               nonempty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         text_byte,
	output logic [1:0]         kind,
	output logic               run_last
);

	function automatic logic [7:0] caesar_back(input logic [7:0] c,
		input logic signed [5:0] k_in);
		logic signed [6:0] k;
		logic signed [5:0] r;
		logic [7:0] base;
		logic [7:0] off;
		logic lower;
		logic upper;
		k = {k_in[5], k_in};
		if (k < 7'sd0) k = k + 7'sd26;
		if (k < 7'sd0) k = k + 7'sd26;
		if (k >= 7'sd26) k = k - 7'sd26;
		lower = (c >= 8'h61) && (c <= 8'h7A);
		upper = (c >= 8'h41) && (c <= 8'h5A);
		base  = lower ? 8'h61 : 8'h41;
		off   = c - base;
		r = $signed({1'b0, off[4:0]}) - $signed({1'b0, k[4:0]});
		if (r < 6'sd0) r = r + 6'sd26;
		if (lower || upper) begin
			return base + {3'd0, r[4:0]};
		end
		return c;
	endfunction

	logic out_valid_q;
	logic phase_q; // message byte of the head entry already sent
	logic load;
	logic send_msg;

	assign out_valid = out_valid_q;
	assign load      = !out_valid_q || !out_stall;
	assign send_msg  = head.has_msg && !phase_q;
	assign pop       = load && nonempty && (!send_msg || !head.has_tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= nonempty;
			if (nonempty) begin
				phase_q <= send_msg && head.has_tail;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && nonempty) begin
			if (send_msg) begin
				text_byte <= caesar_back(head.msg, key);
				kind      <= lsbx_pkg::KIND_TEXT;
				run_last  <= !head.has_tail;
			end else begin
				text_byte <= 8'd0;
				kind      <= head.tail_kind;
				run_last  <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/lsb_stego_extract_caesar_top.sv @@
// Top level of the LSB text extractor with Caesar decryption.
// Depends on lsbx_pkg, lsbx_front, lsbx_queue, lsbx_back.
//
// One pixel is taken per clock while in_stall is low; in_stall rises only
// when the four-entry result queue is full. A pixel that yields a result
// passes through the queue into the registered output. The output side
// delivers one result per clock while out_stall is low: a pixel that
// releases a message byte and also ends the image without a marker yields
// two results, the byte and then the end-of-run status, every other pixel
// at most one. Pixels after the end marker produce nothing until the
// image's last pixel clears the state. shift_key is to be written through
// cfg_we/cfg_wdata only while idle; the block does not enforce this.
module lsb_stego_extract_caesar_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       last_pixel,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] text_byte,
	output logic [1:0] kind,
	output logic       run_last
);

	logic signed [5:0]  key_q;
	logic               take;
	logic               push;
	lsbx_pkg::pix_res_t push_data;
	lsbx_pkg::pix_res_t head;
	logic               nonempty;
	logic               full;
	logic               pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q <= $signed(cfg_wdata);
		end
	end

	assign in_stall = full;
	assign take     = in_valid && !full;

	lsbx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.last_pixel(last_pixel),
		.push      (push),
		.push_data (push_data)
	);

	lsbx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.nonempty (nonempty),
		.full     (full)
	);

	lsbx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (key_q),
		.head     (head),
		.nonempty (nonempty),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.text_byte(text_byte),
		.kind     (kind),
		.run_last (run_last)
	);

endmodule
